@@ design/qev_pkg.sv @@
// ----------------------------------------------------------------------------
// qev_pkg
// Shared types, constants and the transition table of the encoder decoder.
// ----------------------------------------------------------------------------
package qev_pkg;

  localparam int CHANNELS   = 2;
  localparam int CH_W       = 1;
  localparam int HIST_W     = 4;
  localparam int COUNT_W    = 8;
  localparam int QUOT_W     = 6;
  localparam int TIME_W     = 32;
  localparam int THR_W      = 16;
  localparam int STEPS_W    = 9;
  localparam int MULT_SH_W  = 2;
  localparam int CFG_IDX_W  = 2;

  localparam int MICROSTEPS_PER_STEP = 4;

  localparam logic [THR_W-1:0] SLOW_RESET   = THR_W'(500);
  localparam logic [THR_W-1:0] MEDIUM_RESET = THR_W'(200);
  localparam logic [THR_W-1:0] FAST_RESET   = THR_W'(50);

  localparam logic [CFG_IDX_W-1:0] REG_SLOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST   = 2'd2;

  // Event request handed from the decoder to the velocity stage
  typedef struct packed {
    logic [CH_W-1:0]          ch;
    logic signed [QUOT_W-1:0] quot;
    logic [TIME_W-1:0]        now_ms;
  } event_t;

  typedef struct packed {
    logic [THR_W-1:0] slow;
    logic [THR_W-1:0] mid;
    logic [THR_W-1:0] fast;
  } thresholds_t;

  function automatic logic signed [1:0] transition_delta(input logic [HIST_W-1:0] h);
    logic signed [1:0] d;
    unique case (h)
      4'h1, 4'h7, 4'h8, 4'hE: d = 2'sd1;
      4'h2, 4'h4, 4'hB, 4'hD: d = -2'sd1;
      default:                d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

@@ design/quadrature_encoder_velocity.sv @@
// ----------------------------------------------------------------------------
// quadrature_encoder_velocity
// Two-channel quadrature decoder with velocity-scaled detent events.
//
//   channel  dir  handshake          payload
//   s_axis   in   tvalid/tready      tuser=channel, tlast=batch_end, tdata
//   m_axis   out  tvalid/tready      tuser=control, tdata=steps
//   cfg      in   cfg_we             cfg_index, cfg_data
//
// One sample per cycle; decoder updates the channel state in the accept
// cycle. An event is written into the event queue at the accept edge and
// moves to the output register when that register is free or being drained.
// s_tready drops only while the two-entry event queue is full.
// Synchronous reset clears history, counts and event times and reloads the default thresholds.
// ----------------------------------------------------------------------------
module quadrature_encoder_velocity (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [1:0] ab_sample, [33:2] now_ms, zero fill
  input  logic        s_tlast,   // batch_end
  input  logic [0:0]  s_tuser,   // [0] channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [8:0] steps (signed), zero fill
  output logic [0:0]  m_tuser,   // [0] control
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic                       accept;
  logic                       push;
  qev_pkg::event_t            push_data;
  logic                       q_full;
  logic                       q_valid;
  logic                       pop;
  qev_pkg::event_t            q_data;
  logic signed [8:0]          out_steps;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  qev_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .channel   (s_tuser),
    .ab_sample (s_tdata[1:0]),
    .batch_end (s_tlast),
    .now_ms    (s_tdata[33:2]),
    .push      (push),
    .push_data (push_data)
  );

  qev_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  qev_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_ch    (m_tuser),
    .out_steps (out_steps)
  );

  assign m_tdata = {7'd0, out_steps};

endmodule

@@ design/qev_front.sv @@
// ----------------------------------------------------------------------------
// qev_front
// Per-channel phase history and saturating microstep count; raises an
// event request with the truncated detent quotient at a batch end once the count reaches a full detent.
// ----------------------------------------------------------------------------
module qev_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [qev_pkg::CH_W-1:0]    channel,
  input  logic [1:0]                  ab_sample,
  input  logic                        batch_end,
  input  logic [qev_pkg::TIME_W-1:0]  now_ms,
  output logic                        push,
  output qev_pkg::event_t             push_data
);

  logic [qev_pkg::HIST_W-1:0]         history [qev_pkg::CHANNELS];
  logic signed [qev_pkg::COUNT_W-1:0] count   [qev_pkg::CHANNELS];

  logic                               ch_ok;
  logic [qev_pkg::HIST_W-1:0]         hist_next;
  logic signed [qev_pkg::COUNT_W:0]   sum;
  logic signed [qev_pkg::COUNT_W-1:0] count_sat;
  logic signed [qev_pkg::COUNT_W-1:0] biased;
  logic signed [qev_pkg::COUNT_W-1:0] quot_full;
  logic signed [qev_pkg::COUNT_W-1:0] remainder;
  logic                               fire;

  always_comb begin
    ch_ok     = (32'(channel) < qev_pkg::CHANNELS);
    hist_next = {history[channel][1:0], ab_sample};
    sum       = (qev_pkg::COUNT_W+1)'(count[channel])
              + (qev_pkg::COUNT_W+1)'(qev_pkg::transition_delta(hist_next));
    if (sum > 9'sd127) begin
      count_sat = 8'sd127;
    end else if (sum < -9'sd128) begin
      count_sat = -8'sd128;
    end else begin
      count_sat = sum[qev_pkg::COUNT_W-1:0];
    end
    // truncate toward zero: bias negatives by divisor-1 before the shift
    biased    = count_sat[qev_pkg::COUNT_W-1] ? count_sat + 8'sd3 : count_sat;
    quot_full = biased >>> 2;
    remainder = count_sat - (quot_full <<< 2);
    fire      = accept && ch_ok && batch_end
              && (count_sat >= 8'sd4 || count_sat <= -8'sd4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < qev_pkg::CHANNELS; i++) begin
        history[i] <= '0;
        count[i]   <= '0;
      end
    end else if (accept && ch_ok) begin
      history[channel] <= hist_next;
      count[channel]   <= fire ? remainder : count_sat;
    end
  end

  assign push             = fire;
  assign push_data.ch     = channel;
  assign push_data.quot   = quot_full[qev_pkg::QUOT_W-1:0];
  assign push_data.now_ms = now_ms;

endmodule

@@ design/qev_queue.sv @@
// ----------------------------------------------------------------------------
// qev_queue
// Two-entry event queue between the decoder and the velocity stage.
// ----------------------------------------------------------------------------
module qev_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  qev_pkg::event_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output qev_pkg::event_t pop_data
);

  qev_pkg::event_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ design/qev_back.sv @@
// ----------------------------------------------------------------------------
// qev_back
// Velocity stage: elapsed time since the channel's last event selects the
// multiplier; the scaled steps land in the output register.
// ----------------------------------------------------------------------------
module qev_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [qev_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qev_pkg::THR_W-1:0]           cfg_data,
  input  logic                                q_valid,
  input  qev_pkg::event_t                     q_data,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [qev_pkg::CH_W-1:0]            out_ch,
  output logic signed [qev_pkg::STEPS_W-1:0]  out_steps
);

  qev_pkg::thresholds_t              thr;
  logic [qev_pkg::TIME_W-1:0]        last_ms [qev_pkg::CHANNELS];
  logic [qev_pkg::TIME_W-1:0]        interval;
  logic [qev_pkg::MULT_SH_W-1:0]     mult_sh;
  logic signed [qev_pkg::STEPS_W-1:0] steps;

  assign pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    interval = q_data.now_ms - last_ms[q_data.ch];
    priority if (interval > qev_pkg::TIME_W'(thr.slow)) begin
      mult_sh = 2'd0;
    end else if (interval > qev_pkg::TIME_W'(thr.mid)) begin
      mult_sh = 2'd1;
    end else if (interval > qev_pkg::TIME_W'(thr.fast)) begin
      mult_sh = 2'd2;
    end else begin
      mult_sh = 2'd3;
    end
    // -32 x 8 gives -256, which still fits the 9-bit signed range
    steps = qev_pkg::STEPS_W'(q_data.quot) <<< mult_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.slow <= qev_pkg::SLOW_RESET;
      thr.mid  <= qev_pkg::MEDIUM_RESET;
      thr.fast <= qev_pkg::FAST_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qev_pkg::REG_SLOW:   thr.slow <= cfg_data;
        qev_pkg::REG_MEDIUM: thr.mid  <= cfg_data;
        qev_pkg::REG_FAST:   thr.fast <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < qev_pkg::CHANNELS; i++) begin
        last_ms[i] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        last_ms[q_data.ch] <= q_data.now_ms;
        out_valid          <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_ch    <= q_data.ch;
      out_steps <= steps;
    end
  end

endmodule

@@ design/qev_checker.sv @@
// ----------------------------------------------------------------------------
// qev_checker
// Port-level checks on the encoder block, bound to the top level.
// ----------------------------------------------------------------------------
module qev_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output item changed");

  // an event always carries at least one detent
  a_steps_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8:0] != 9'd0) && (m_tdata[15:9] == 7'd0))
    else $error("output item with zero steps or dirty padding");

  // a fresh result must trace back to an earlier accepted sample
  a_out_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("output item without a matching sample");

  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> s_tready)
    else $error("input not ready after reset");

endmodule

bind quadrature_encoder_velocity qev_checker u_qev_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-channel quadrature decoder. Gray-code runs,
// broken runs and pin noise go in over the sample stream. A scoreboard
// predicts each detent event and checks the output stream in order. The
// thresholds are swept through several settings, and both streams stall at
// random.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [qev_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [qev_pkg::CH_W-1:0]           control;
    logic signed [qev_pkg::STEPS_W-1:0] steps;
  } detent_event_t;

  class detent_scoreboard;
    detent_event_t              expected_events[$];
    logic [qev_pkg::HIST_W-1:0] phase_hist [qev_pkg::CHANNELS];
    int                         microsteps [qev_pkg::CHANNELS];
    logic [qev_pkg::TIME_W-1:0] last_event [qev_pkg::CHANNELS];
    logic [qev_pkg::THR_W-1:0]  slow_ms, medium_ms, fast_ms;
    int                         delta_of [16];
    int                         errors, samples, events;

    function new();
      delta_of = '{0, 1, -1, 0, -1, 0, 0, 1, 1, 0, 0, -1, 0, -1, 1, 0};
      slow_ms   = qev_pkg::SLOW_RESET;
      medium_ms = qev_pkg::MEDIUM_RESET;
      fast_ms   = qev_pkg::FAST_RESET;
      for (int i = 0; i < qev_pkg::CHANNELS; i++) begin
        phase_hist[i] = '0;
        microsteps[i] = 0;
        last_event[i] = '0;
      end
      errors  = 0;
      samples = 0;
      events  = 0;
    endfunction

    function void write_reg(logic [qev_pkg::CFG_IDX_W-1:0] idx,
                            logic [qev_pkg::THR_W-1:0] val);
      case (idx)
        qev_pkg::REG_SLOW:   slow_ms = val;
        qev_pkg::REG_MEDIUM: medium_ms = val;
        qev_pkg::REG_FAST:   fast_ms = val;
        default: ;
      endcase
    endfunction

    function void note_sample(logic [qev_pkg::CH_W-1:0] ch, logic [1:0] ab,
                              logic batch_end, logic [qev_pkg::TIME_W-1:0] now);
      logic [qev_pkg::TIME_W-1:0] interval;
      int            mult;
      int            c;
      detent_event_t ev;
      samples++;
      phase_hist[ch] = {phase_hist[ch][1:0], ab};
      c = microsteps[ch] + delta_of[phase_hist[ch]];
      if (c > 127) c = 127;
      if (c < -128) c = -128;
      microsteps[ch] = c;
      if (!batch_end || (c < qev_pkg::MICROSTEPS_PER_STEP &&
                         c > -qev_pkg::MICROSTEPS_PER_STEP)) return;
      // elapsed time wraps modulo 2^32; first threshold that holds wins
      interval = now - last_event[ch];
      if (interval > slow_ms) mult = 1;
      else if (interval > medium_ms) mult = 2;
      else if (interval > fast_ms) mult = 4;
      else mult = 8;
      ev.control = ch;
      ev.steps   = qev_pkg::STEPS_W'((c / qev_pkg::MICROSTEPS_PER_STEP) * mult);
      microsteps[ch] = c % qev_pkg::MICROSTEPS_PER_STEP;
      last_event[ch] = now;
      expected_events.push_back(ev);
    endfunction

    function void check_result(logic [qev_pkg::CH_W-1:0] control,
                               logic signed [qev_pkg::STEPS_W-1:0] steps);
      detent_event_t ev;
      events++;
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected event: expected none, actual control %0d steps %0d",
                 $time, control, steps);
        return;
      end
      ev = expected_events.pop_front();
      if (ev.control !== control) begin
        errors++;
        $display("%0t: control mismatch: expected %0d, actual %0d", $time, ev.control, control);
      end
      if (ev.steps !== steps) begin
        errors++;
        $display("%0t: steps mismatch: expected %0d, actual %0d", $time, ev.steps, steps);
      end
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [39:0]                     s_tdata;   // [1:0] ab_sample, [33:2] now_ms, zero fill
  logic                            s_tlast;   // batch_end
  logic [0:0]                      s_tuser;   // [0] channel
  logic                            m_tvalid;
  logic                            m_tready;
  logic [15:0]                     m_tdata;   // [8:0] steps (signed), zero fill
  logic [0:0]                      m_tuser;   // [0] control
  logic                            cfg_we;
  logic [qev_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [qev_pkg::THR_W-1:0]       cfg_data;

  detent_scoreboard sb = new();
  logic [1:0]                 pin_state [qev_pkg::CHANNELS];
  logic [qev_pkg::TIME_W-1:0] clock_ms;
  int                         burst_left;
  int                         settings_seen;
  bit                         held_off;

  quadrature_encoder_velocity dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [1:0] next_phase(logic [1:0] ab, bit fwd);
    case (ab)
      2'd0:    return fwd ? 2'd1 : 2'd2;
      2'd1:    return fwd ? 2'd3 : 2'd0;
      2'd3:    return fwd ? 2'd2 : 2'd1;
      default: return fwd ? 2'd0 : 2'd3;
    endcase
  endfunction

  // sender works in bursts with random gaps between them
  task automatic offer_sample(logic [qev_pkg::CH_W-1:0] ch, logic [1:0] ab,
                              logic batch_end, logic [qev_pkg::TIME_W-1:0] now);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= ch;
    s_tlast  <= batch_end;
    s_tdata  <= {6'd0, now, ab};
    do @(posedge clk); while (!s_tready);
    pin_state[ch] = ab;
    sb.note_sample(ch, ab, batch_end, now);
  endtask

  task automatic gray_run(logic [qev_pkg::CH_W-1:0] ch, bit fwd, int n,
                          logic [qev_pkg::TIME_W-1:0] now, bit close);
    for (int i = 0; i < n; i++)
      offer_sample(ch, next_phase(pin_state[ch], fwd), close && (i == n - 1), now);
  endtask

  task automatic wait_idle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    // a sample with no event may still be in flight
    repeat (8) @(posedge clk);
  endtask

  task automatic set_thresholds(logic [qev_pkg::THR_W-1:0] slow,
                                logic [qev_pkg::THR_W-1:0] mid,
                                logic [qev_pkg::THR_W-1:0] fast, bit poke_unused);
    logic [qev_pkg::CFG_IDX_W-1:0] idx [4];
    logic [qev_pkg::THR_W-1:0]     val [4];
    idx = '{qev_pkg::REG_SLOW, qev_pkg::REG_MEDIUM, qev_pkg::REG_FAST, REG_UNUSED};
    val = '{slow, mid, fast, qev_pkg::THR_W'($urandom)};
    for (int i = 0; i < (poke_unused ? 4 : 3); i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    settings_seen++;
  endtask

  task automatic random_traffic(int n_items);
    int                        sent;
    int                        len;
    int                        kind;
    logic [qev_pkg::CH_W-1:0]  ch;
    logic [qev_pkg::THR_W-1:0] thr;
    sent = 0;
    while (sent < n_items) begin
      ch   = qev_pkg::CH_W'($urandom_range(0, qev_pkg::CHANNELS - 1));
      kind = $urandom_range(0, 9);
      clock_ms += ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 600);
      if (kind < 6) begin
        len = $urandom_range(1, 12);
        gray_run(ch, bit'($urandom_range(0, 1)), len, clock_ms, 1'b1);
      end else if (kind == 6) begin
        // land the interval on a threshold or just past it
        case ($urandom_range(0, 2))
          0:       thr = sb.slow_ms;
          1:       thr = sb.medium_ms;
          default: thr = sb.fast_ms;
        endcase
        clock_ms = sb.last_event[ch] + thr + $urandom_range(0, 1);
        len = $urandom_range(4, 8);
        gray_run(ch, bit'($urandom_range(0, 1)), len, clock_ms, 1'b1);
      end else if (kind < 9) begin
        len = 1;
        offer_sample(ch, 2'($urandom), 1'($urandom), clock_ms);
      end else begin
        // run broken by a skipped phase
        len = $urandom_range(2, 7);
        gray_run(ch, bit'($urandom_range(0, 1)), len - 1, clock_ms, 1'b0);
        offer_sample(ch, ~pin_state[ch], 1'b1, clock_ms);
      end
      sent += len;
    end
  endtask

  initial begin
    int wait_cycles;
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tlast    <= 1'b0;
    s_tuser    <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= qev_pkg::REG_SLOW;
    cfg_data   <= '0;
    burst_left = 0;
    settings_seen = 1;
    clock_ms   = '0;
    for (int i = 0; i < qev_pkg::CHANNELS; i++) pin_state[i] = 2'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: each multiplier, remainders, both directions, timer wrap
    gray_run(1'b0, 1'b1, 4, 32'd1000, 1'b1);
    gray_run(1'b0, 1'b1, 4, 32'd1300, 1'b1);
    gray_run(1'b0, 1'b1, 5, 32'd1400, 1'b1);
    gray_run(1'b0, 1'b1, 3, 32'd1420, 1'b1);
    gray_run(1'b1, 1'b0, 6, 32'hFFFF_FFFF, 1'b1);
    gray_run(1'b1, 1'b0, 2, 32'h0000_001F, 1'b1);
    offer_sample(1'b0, ~pin_state[0], 1'b1, 32'd0);   // illegal jump, below one detent
    clock_ms = 32'h0000_001F;
    random_traffic(60);

    wait_idle();
    set_thresholds('0, '0, '0, 1'b1);
    random_traffic(60);

    wait_idle();
    set_thresholds('1, '1, '1, 1'b0);
    gray_run(1'b0, 1'b1, 132, clock_ms, 1'b1);       // saturates upward
    random_traffic(30);

    wait_idle();
    set_thresholds(qev_pkg::THR_W'(50), qev_pkg::THR_W'(200),
                   qev_pkg::THR_W'(500), 1'b0);      // out of order
    random_traffic(60);

    wait_idle();
    set_thresholds(qev_pkg::THR_W'($urandom), qev_pkg::THR_W'($urandom),
                   qev_pkg::THR_W'($urandom), 1'b1);
    gray_run(1'b1, 1'b0, 132, clock_ms, 1'b1);       // saturates downward
    random_traffic(30);

    wait_idle();
    set_thresholds(qev_pkg::SLOW_RESET, qev_pkg::MEDIUM_RESET, qev_pkg::FAST_RESET, 1'b0);
    random_traffic(60);

    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: missing events: expected %0d more, actual 0", $time, sb.pending());
    end

    $display("run covered %0d samples, %0d detent events, %0d threshold settings",
             sb.samples, sb.events, settings_seen);
    $display("both streams stalled at random, including one long output hold-off");
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver: random stall patterns in turn, plus one long hold-off
  initial begin
    int cyc;
    int mode;
    m_tready <= 1'b0;
    held_off = 1'b0;
    cyc  = 0;
    mode = 0;
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata[qev_pkg::STEPS_W-1:0]);
      if (!held_off && sb.samples >= 200) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if (cyc % 50 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom);
        2:       m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= cyc[0];
      endcase
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

endmodule
